// ===== hw/rtl/tpp_pkg.sv =====
// Package for the two-plane pixel plotter.
// Holds opcodes, register indexes, state and colour-class enums, the config width, colour constants and reset values.
// No dependencies.
package tpp_pkg;

    typedef enum logic [1:0] {
        OP_PLOT = 2'd0,
        OP_FILL = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_ROTATION     = 3'd0,
        REG_WHITE_CODE   = 3'd1,
        REG_BLACK_CODE   = 3'd2,
        REG_RED_CODE     = 3'd3,
        REG_BLACK_INK    = 3'd4,
        REG_BLACK_CLEAR  = 3'd5,
        REG_RED_INK      = 3'd6,
        REG_RED_CLEAR    = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_RMW,
        S_FILL,
        S_PUSH
    } state_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_BLACK,
        CLS_RED
    } color_class_t;

    localparam int unsigned CFG_DATA_W = 16;

    // Colour classification for codes that match none of the configured ones
    localparam logic [15:0] MASK_RB    = 16'hF100;
    localparam logic [15:0] RED_LIMIT  = 16'(16'hF100 / 2);
    localparam logic [15:0] MASK_G     = 16'h07E0;
    localparam logic [15:0] MASK_B     = 16'h001F;
    localparam logic [8:0]  DARK_LIMIT = 9'(3 * 255 / 2);

    localparam logic [15:0] WHITE_RESET = 16'hFFFF;
    localparam logic [15:0] BLACK_RESET = 16'h0000;
    localparam logic [15:0] RED_RESET   = 16'hF800;
    localparam logic [7:0]  INK_RESET   = 8'hFF;
    localparam logic [7:0]  CLEAR_RESET = 8'h00;

endpackage

// ===== hw/rtl/two_plane_pixel_plotter_top.sv =====
// Two-plane pixel plotter: black and red 1-bpp planes in two on-chip memories.
// Depends on tpp_pkg (scoped names only).
//
//   Channel   Direction  Handshake           Payload
//   ------    ---------  ------------------  ------------------------------------------
//   input     in         in_valid/in_stall   opcode, pixel_x, pixel_y, pixel_color,
//                                            read_index
//   output    out        out_valid/out_stall touched_index, black_byte, red_byte,
//                                            in_bounds
//   config    in         cfg_we              cfg_index, cfg_data
//
// Steps: plot goes from accept (bounds/rotate) through multiply row offset, address and
//   memory read, then modify and write back; an in-range read skips the multiply step;
//   clipped plots, out-of-range reads and the unused opcode finish in the accept cycle.
//   Fill writes one byte pair per cycle through the single write port, sweeping all
//   PANEL_WIDTH*PANEL_HEIGHT/8 byte addresses after the accept cycle.
// One transaction is in flight at a time; in_stall is high until its result is loaded
//   into the output register, which may still hold an earlier unclaimed result.
// Reset initialises control and configuration to their defaults; the planes are not cleared.
// out_stall holds the output register; a finished result then waits in a pending slot.
module two_plane_pixel_plotter_top #(
    parameter int PANEL_WIDTH  = 1304,
    parameter int PANEL_HEIGHT = 984
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic signed [15:0] pixel_x,
    input  logic signed [15:0] pixel_y,
    input  logic [15:0] pixel_color,
    input  logic [17:0] read_index,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [17:0] touched_index,
    output logic [7:0]  black_byte,
    output logic [7:0]  red_byte,
    output logic        in_bounds,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [tpp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Geometry derived from the panel size
    localparam int PLANE_BYTES = PANEL_WIDTH * PANEL_HEIGHT / 8;
    localparam int AW          = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
    localparam int IW          = AW + 2;
    localparam int MAX_DIM     = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CW          = $clog2(MAX_DIM);
    localparam int WW          = $clog2(PANEL_WIDTH + 1);
    localparam int PRW         = CW + WW;

    localparam logic [CW-1:0] W_M1      = CW'(PANEL_WIDTH - 1);
    localparam logic [CW-1:0] H_M1      = CW'(PANEL_HEIGHT - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PLANE_BYTES - 1);

    // Plane memories: one write port, one registered read port each
    logic [7:0] black_mem [PLANE_BYTES];
    logic [7:0] red_mem   [PLANE_BYTES];
    logic [7:0] black_rd_reg;
    logic [7:0] red_rd_reg;

    // Configuration
    logic [1:0]  rotation_reg;
    logic [15:0] white_code_reg;
    logic [15:0] black_code_reg;
    logic [15:0] red_code_reg;
    logic [7:0]  black_ink_reg;
    logic [7:0]  black_clear_reg;
    logic [7:0]  red_ink_reg;
    logic [7:0]  red_clear_reg;

    // Control
    tpp_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic [AW-1:0]   fill_cnt_reg, fill_cnt_next;

    // Transaction context
    tpp_pkg::op_t          op_reg;
    tpp_pkg::color_class_t cls_reg;
    logic [CW-1:0]         rx_reg;
    logic [CW-1:0]         ry_reg;
    logic [PRW-1:0]        prod_reg;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [17:0]           read_idx_reg;
    logic [7:0]            fill_b_reg;
    logic [7:0]            fill_r_reg;

    // Pending result and output register
    logic [17:0] pend_idx_reg;
    logic [7:0]  pend_b_reg;
    logic [7:0]  pend_r_reg;
    logic        pend_ok_reg;
    logic [17:0] out_idx_reg;
    logic [7:0]  out_b_reg;
    logic [7:0]  out_r_reg;
    logic        out_ok_reg;

    // Combinational
    logic          in_acc;
    logic          out_free;
    logic          out_load;
    tpp_pkg::op_t  op_in;
    logic [15:0]   bound_w;
    logic [15:0]   bound_h;
    logic          plot_ok;
    logic          read_ok;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    logic [15:0]   rb_part;
    logic [8:0]    shade_sum;
    tpp_pkg::color_class_t cls_in;
    logic [IW-1:0] plot_sum;
    logic [7:0]    bit_mask;
    logic [7:0]    new_b;
    logic [7:0]    new_r;

    logic          fin;
    logic [17:0]   fin_idx;
    logic [7:0]    fin_b;
    logic [7:0]    fin_r;
    logic          fin_ok;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wb;
    logic [7:0]    mem_wr;
    logic [AW-1:0] rd_addr;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != tpp_pkg::S_IDLE);
    assign op_in    = tpp_pkg::op_t'(opcode);

    // Bounds swap on quarter-turn rotations
    assign bound_w = rotation_reg[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
    assign bound_h = rotation_reg[0] ? 16'(PANEL_WIDTH)  : 16'(PANEL_HEIGHT);
    assign plot_ok = !pixel_x[15] && !pixel_y[15]
                     && ($unsigned(pixel_x) < bound_w) && ($unsigned(pixel_y) < bound_h);
    assign read_ok = (32'(read_index) < 32'(PLANE_BYTES));

    assign sx = CW'($unsigned(pixel_x));
    assign sy = CW'($unsigned(pixel_y));

    // Map rotated coordinates back to panel coordinates
    always_comb
    begin
        case (rotation_reg)
            2'd1:
            begin
                rx = W_M1 - sy;
                ry = sx;
            end
            2'd2:
            begin
                rx = W_M1 - sx;
                ry = H_M1 - sy;
            end
            2'd3:
            begin
                rx = sy;
                ry = H_M1 - sx;
            end
            default:
            begin
                rx = sx;
                ry = sy;
            end
        endcase
    end

    // Colour class: configured codes first, then the mask and threshold rules
    assign rb_part   = pixel_color & tpp_pkg::MASK_RB;
    assign shade_sum = 9'(rb_part >> 11) + 9'((pixel_color & tpp_pkg::MASK_G) >> 5)
                       + 9'(pixel_color & tpp_pkg::MASK_B);

    always_comb
    begin
        if (pixel_color == white_code_reg)
            cls_in = tpp_pkg::CLS_NONE;
        else if (pixel_color == black_code_reg)
            cls_in = tpp_pkg::CLS_BLACK;
        else if (pixel_color == red_code_reg)
            cls_in = tpp_pkg::CLS_RED;
        else if (rb_part > tpp_pkg::RED_LIMIT)
            cls_in = tpp_pkg::CLS_RED;
        else if (shade_sum < tpp_pkg::DARK_LIMIT)
            cls_in = tpp_pkg::CLS_BLACK;
        else
            cls_in = tpp_pkg::CLS_NONE;
    end

    assign plot_sum = IW'(rx_reg >> 3) + IW'(prod_reg >> 3);

    // Read-modify-write of the addressed byte pair
    assign bit_mask = 8'h80 >> rx_reg[2:0];
    assign new_b    = (black_rd_reg & ~bit_mask)
                      | ((cls_reg == tpp_pkg::CLS_BLACK) ? bit_mask : 8'h00);
    assign new_r    = (red_rd_reg & ~bit_mask)
                      | ((cls_reg == tpp_pkg::CLS_RED) ? bit_mask : 8'h00);

    // Sequencer: next state, memory ports and finished result
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fin        = 1'b0;
        fin_idx    = '0;
        fin_b      = '0;
        fin_r      = '0;
        fin_ok     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = fill_cnt_reg;
        mem_wb     = fill_b_reg;
        mem_wr     = fill_r_reg;
        rd_addr    = AW'(read_idx_reg);

        unique case (state_reg)
            tpp_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op_in)
                        tpp_pkg::OP_PLOT:
                        begin
                            if (plot_ok)
                                state_next = tpp_pkg::S_MUL;
                            else
                                fin = 1'b1;
                        end
                        tpp_pkg::OP_FILL:
                            state_next = tpp_pkg::S_FILL;
                        tpp_pkg::OP_READ:
                        begin
                            if (read_ok)
                                state_next = tpp_pkg::S_ADDR;
                            else
                            begin
                                fin     = 1'b1;
                                fin_idx = read_index;
                            end
                        end
                        default:
                            fin = 1'b1;
                    endcase
                end
            end
            tpp_pkg::S_MUL:
                state_next = tpp_pkg::S_ADDR;
            tpp_pkg::S_ADDR:
            begin
                if (op_reg == tpp_pkg::OP_PLOT)
                begin
                    if (plot_sum < IW'(PLANE_BYTES))
                    begin
                        rd_addr    = AW'(plot_sum);
                        idx_next   = AW'(plot_sum);
                        state_next = tpp_pkg::S_RMW;
                    end
                    else
                        fin = 1'b1;
                end
                else
                begin
                    idx_next   = AW'(read_idx_reg);
                    state_next = tpp_pkg::S_RMW;
                end
            end
            tpp_pkg::S_RMW:
            begin
                fin     = 1'b1;
                fin_ok  = 1'b1;
                fin_idx = 18'(idx_reg);
                if (op_reg == tpp_pkg::OP_PLOT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wb    = new_b;
                    mem_wr    = new_r;
                    fin_b     = new_b;
                    fin_r     = new_r;
                end
                else
                begin
                    fin_b = black_rd_reg;
                    fin_r = red_rd_reg;
                end
            end
            tpp_pkg::S_FILL:
            begin
                mem_we = 1'b1;
                if (fill_cnt_reg == LAST_ADDR)
                begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                    fin_b  = fill_b_reg;
                    fin_r  = fill_r_reg;
                end
            end
            tpp_pkg::S_PUSH:
            begin
                if (out_free)
                    state_next = tpp_pkg::S_IDLE;
            end
            default:
                state_next = tpp_pkg::S_IDLE;
        endcase

        if (fin)
            state_next = out_free ? tpp_pkg::S_IDLE : tpp_pkg::S_PUSH;
    end

    assign out_load       = (fin || (state_reg == tpp_pkg::S_PUSH)) && out_free;
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        if (in_acc)
            fill_cnt_next = '0;
        else if (state_reg == tpp_pkg::S_FILL)
            fill_cnt_next = fill_cnt_reg + 1'b1;
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tpp_pkg::S_IDLE;
            out_valid_reg   <= 1'b0;
            fill_cnt_reg    <= '0;
            rotation_reg    <= 2'd0;
            white_code_reg  <= tpp_pkg::WHITE_RESET;
            black_code_reg  <= tpp_pkg::BLACK_RESET;
            red_code_reg    <= tpp_pkg::RED_RESET;
            black_ink_reg   <= tpp_pkg::INK_RESET;
            black_clear_reg <= tpp_pkg::CLEAR_RESET;
            red_ink_reg     <= tpp_pkg::INK_RESET;
            red_clear_reg   <= tpp_pkg::CLEAR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fill_cnt_reg  <= fill_cnt_next;
            if (cfg_we)
            begin
                unique case (tpp_pkg::reg_idx_t'(cfg_index))
                    tpp_pkg::REG_ROTATION:    rotation_reg    <= cfg_data[1:0];
                    tpp_pkg::REG_WHITE_CODE:  white_code_reg  <= cfg_data;
                    tpp_pkg::REG_BLACK_CODE:  black_code_reg  <= cfg_data;
                    tpp_pkg::REG_RED_CODE:    red_code_reg    <= cfg_data;
                    tpp_pkg::REG_BLACK_INK:   black_ink_reg   <= cfg_data[7:0];
                    tpp_pkg::REG_BLACK_CLEAR: black_clear_reg <= cfg_data[7:0];
                    tpp_pkg::REG_RED_INK:     red_ink_reg     <= cfg_data[7:0];
                    tpp_pkg::REG_RED_CLEAR:   red_clear_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Transaction payload; captured at accept and advanced per stage
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg       <= op_in;
            cls_reg      <= cls_in;
            rx_reg       <= rx;
            ry_reg       <= ry;
            read_idx_reg <= read_index;
            fill_b_reg   <= (pixel_color == black_code_reg) ? black_ink_reg : black_clear_reg;
            fill_r_reg   <= (pixel_color == red_code_reg) ? red_ink_reg : red_clear_reg;
        end
        if (state_reg == tpp_pkg::S_MUL)
            prod_reg <= PRW'(ry_reg) * PRW'(PANEL_WIDTH);
        idx_reg <= idx_next;
        if (fin && !out_free)
        begin
            pend_idx_reg <= fin_idx;
            pend_b_reg   <= fin_b;
            pend_r_reg   <= fin_r;
            pend_ok_reg  <= fin_ok;
        end
        if (out_load)
        begin
            out_idx_reg <= fin ? fin_idx : pend_idx_reg;
            out_b_reg   <= fin ? fin_b : pend_b_reg;
            out_r_reg   <= fin ? fin_r : pend_r_reg;
            out_ok_reg  <= fin ? fin_ok : pend_ok_reg;
        end
    end

    // Plane memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            black_mem[mem_waddr] <= mem_wb;
            red_mem[mem_waddr]   <= mem_wr;
        end
        black_rd_reg <= black_mem[rd_addr];
        red_rd_reg   <= red_mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign touched_index = out_idx_reg;
    assign black_byte    = out_b_reg;
    assign red_byte      = out_r_reg;
    assign in_bounds     = out_ok_reg;

    // Write-back only follows an address cycle that issued the read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpp_pkg::S_RMW) |-> ($past(state_reg) == tpp_pkg::S_ADDR))
        else $error("read-modify-write without preceding address cycle");

    // Fill sweep advances one byte per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpp_pkg::S_FILL && fill_cnt_reg != '0)
        |-> ($past(state_reg) == tpp_pkg::S_FILL
             && fill_cnt_reg == AW'($past(fill_cnt_reg) + 1'b1)))
        else $error("fill sweep skipped or repeated an address");

    // A pending result drains into a free output slot, with the sequencer idle in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpp_pkg::S_PUSH && out_free)
        |=> (state_reg == tpp_pkg::S_IDLE && out_valid_reg))
        else $error("pending result not delivered");

    // Dropped or rejected operations report zero bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_b_reg == 8'h00 && out_r_reg == 8'h00))
        else $error("clipped result carries plane data");

endmodule
